// File: rtl/core/sscp_pkg.sv
// Shared widths, types and constants for the segment closest-point pipeline.
package sscp_pkg;

    localparam int CW      = 32;          // coordinate, Q16.16
    localparam int DW      = CW + 1;      // coordinate difference
    localparam int PW      = 2 * DW;      // product of two differences
    localparam int KW      = 54;          // floored dot product
    localparam int HW      = KW / 2;      // split point for wide products
    localparam int HP      = 2 * HW + 2;  // partial product
    localparam int WW      = 2 * KW;      // full product of two dot products
    localparam int RATIO_W = 106;         // divider operand width
    localparam int FRAC    = 16;
    localparam int QW      = FRAC + 1;    // Q1.16 parameter
    localparam int GW      = 50;
    localparam int LW      = 16;
    localparam int DIV_LAT = FRAC + 1;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [KW-1:0] dot_t;
    typedef logic [QW-1:0]        frac_t;
    typedef logic [LW-1:0]        lim_t;
    typedef logic [GW-1:0]        gap_t;

    localparam frac_t ONE_Q16 = frac_t'(1 << FRAC);
    localparam gap_t  GAP_MAX = '1;

endpackage

// File: rtl/core/sscp_if.sv
// Channel interfaces: query, result and configuration write.
interface sscp_query_if;
    import sscp_pkg::*;
    logic   valid;
    logic   ready;
    coord_t seg1_start_x;
    coord_t seg1_start_y;
    coord_t seg1_start_z;
    coord_t seg1_end_x;
    coord_t seg1_end_y;
    coord_t seg1_end_z;
    coord_t seg2_start_x;
    coord_t seg2_start_y;
    coord_t seg2_start_z;
    coord_t seg2_end_x;
    coord_t seg2_end_y;
    coord_t seg2_end_z;

    modport source (
        output valid, seg1_start_x, seg1_start_y, seg1_start_z,
        seg1_end_x, seg1_end_y, seg1_end_z, seg2_start_x, seg2_start_y,
        seg2_start_z, seg2_end_x, seg2_end_y, seg2_end_z,
        input ready
    );
    modport sink (
        input valid, seg1_start_x, seg1_start_y, seg1_start_z,
        seg1_end_x, seg1_end_y, seg1_end_z, seg2_start_x, seg2_start_y,
        seg2_start_z, seg2_end_x, seg2_end_y, seg2_end_z,
        output ready
    );
endinterface

interface sscp_result_if;
    import sscp_pkg::*;
    logic   valid;
    logic   ready;
    frac_t  param_first;
    frac_t  param_second;
    coord_t near1_x;
    coord_t near1_y;
    coord_t near1_z;
    coord_t near2_x;
    coord_t near2_y;
    coord_t near2_z;
    gap_t   gap_squared;

    modport source (
        output valid, param_first, param_second, near1_x, near1_y, near1_z,
        near2_x, near2_y, near2_z, gap_squared,
        input ready
    );
    modport sink (
        input valid, param_first, param_second, near1_x, near1_y, near1_z,
        near2_x, near2_y, near2_z, gap_squared,
        output ready
    );
endinterface

interface sscp_cfg_if;
    import sscp_pkg::*;
    logic valid;
    logic ready;
    lim_t data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: rtl/core/sscp_ratio.sv
// Pipelined restoring divider: clamp(num/den, 0, 1) as Q1.16, one quotient bit per stage.
module sscp_ratio #(
    parameter int W = sscp_pkg::RATIO_W
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [W-1:0]   num,
    input  logic signed [W-1:0]   den,
    output sscp_pkg::frac_t       q
);
    import sscp_pkg::*;

    logic [W-1:0]    rem_reg  [FRAC+1];
    logic [W-1:0]    den_reg  [FRAC+1];
    logic [FRAC-1:0] q_reg    [FRAC+1];
    logic            full_reg [FRAC+1];

    // Entry: a zero or negative numerator clears the remainder, a positive num >= den saturates.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            full_reg[0] <= (num > 0) && (num >= den);
            rem_reg[0]  <= (num > 0) ? num : '0;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
        end
    end

    for (genvar k = 1; k <= FRAC; k++)
    begin : g_step
        logic [W-1:0] shift_next;
        logic         fit_next;

        assign shift_next = {rem_reg[k-1][W-2:0], 1'b0};
        assign fit_next   = shift_next >= den_reg[k-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= fit_next ? shift_next - den_reg[k-1] : shift_next;
                q_reg[k]    <= {q_reg[k-1][FRAC-2:0], fit_next};
                den_reg[k]  <= den_reg[k-1];
                full_reg[k] <= full_reg[k-1];
            end
        end
    end

    assign q = full_reg[FRAC] ? ONE_Q16 : {1'b0, q_reg[FRAC]};

endmodule

// File: rtl/core/segment_segment_closest_points.sv
// Top level: closest points between two 3D segments, fully pipelined.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-------------------------------------------
//  query    | in  | valid/ready  | two segments, 12 x Q16.16 coordinates
//  result   | out | valid/ready  | s, t (Q1.16), two points, squared gap
//  cfg      | in  | valid/ready  | degenerate_limit (16 bit), ready always high
//
//  One transaction per cycle while the result is not stalled; the two
//  16-step divider spans run in series (s first, then t, which depends on s).
//  rst_n clears the valid bits and the limit register; data registers hold junk.
//  A stalled result freezes the whole pipeline; query.ready follows at once.
module segment_segment_closest_points #(
    parameter int RATIO_W_P = sscp_pkg::RATIO_W
) (
    input  logic                clk,
    input  logic                rst_n,
    sscp_query_if.sink          query,
    sscp_result_if.source       result,
    sscp_cfg_if.sink            cfg
);
    import sscp_pkg::*;

    localparam int DEPTH = 13 + 2 * DIV_LAT;
    localparam int MW    = DW + QW + 1;
    localparam int BW    = KW + QW + 1;

    typedef logic signed [HP-1:0]      part_t;
    typedef part_t                     part4_t [4];
    typedef logic signed [WW-1:0]      wide_t;
    typedef logic signed [RATIO_W_P-1:0] rat_t;
    typedef logic signed [MW-1:0]      mul_t;
    typedef logic signed [BW-1:0]      bs_t;

    typedef struct {
        coord_t p1 [3];
        coord_t p2 [3];
        diff_t  d1 [3];
        diff_t  d2 [3];
    } pts_t;

    typedef struct {
        pts_t pts;
        dot_t b;
        dot_t e;
        dot_t f;
        logic adeg;
        logic edeg;
    } geo_t;

    typedef struct {
        geo_t  geo;
        frac_t sa;
        frac_t sb;
        frac_t sc;
        logic  neg;
        logic  over;
    } tail_t;

    function automatic diff_t ext(coord_t v);
        return {v[CW-1], v};
    endfunction

    function automatic dot_t dot_floor(prod_t x, prod_t y, prod_t z);
        logic signed [PW+1:0] sum;
        sum = (PW+2)'(x) + (PW+2)'(y) + (PW+2)'(z);
        return KW'(sum >>> FRAC);
    endfunction

    function automatic part4_t split_mul(dot_t x, dot_t y);
        logic signed [HW-1:0] hx;
        logic signed [HW-1:0] hy;
        logic signed [HW:0]   lx;
        logic signed [HW:0]   ly;
        part4_t               p;
        hx   = x[KW-1:HW];
        hy   = y[KW-1:HW];
        lx   = {1'b0, x[HW-1:0]};
        ly   = {1'b0, y[HW-1:0]};
        p[0] = hx * hy;
        p[1] = hx * ly;
        p[2] = lx * hy;
        p[3] = lx * ly;
        return p;
    endfunction

    function automatic wide_t join_parts(part4_t p);
        wide_t hh;
        wide_t mid;
        hh  = WW'(p[0]);
        mid = WW'(p[1]) + WW'(p[2]);
        return (hh <<< (2 * HW)) + (mid <<< HW) + WW'(p[3]);
    endfunction

    logic             adv;
    logic [DEPTH-1:0] vld_reg;
    lim_t             lim_reg;

    // ---------------------------------------------------------------- control
    assign adv         = !vld_reg[DEPTH-1] || result.ready;
    assign query.ready = adv;
    assign cfg.ready   = 1'b1;
    assign result.valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            lim_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[DEPTH-2:0], query.valid};
            end
            if (cfg.valid)
            begin
                lim_reg <= cfg.data;
            end
        end
    end

    // ---------------------------------------------------------------- stage 1
    pts_t  s1_pts_next;
    diff_t s1_r_next [3];
    pts_t  s1_pts_reg;
    diff_t s1_r_reg  [3];

    always_comb
    begin
        coord_t e1 [3];
        coord_t e2 [3];
        s1_pts_next.p1[0] = query.seg1_start_x;
        s1_pts_next.p1[1] = query.seg1_start_y;
        s1_pts_next.p1[2] = query.seg1_start_z;
        s1_pts_next.p2[0] = query.seg2_start_x;
        s1_pts_next.p2[1] = query.seg2_start_y;
        s1_pts_next.p2[2] = query.seg2_start_z;
        e1[0] = query.seg1_end_x;
        e1[1] = query.seg1_end_y;
        e1[2] = query.seg1_end_z;
        e2[0] = query.seg2_end_x;
        e2[1] = query.seg2_end_y;
        e2[2] = query.seg2_end_z;
        for (int i = 0; i < 3; i++)
        begin
            s1_pts_next.d1[i] = ext(e1[i]) - ext(s1_pts_next.p1[i]);
            s1_pts_next.d2[i] = ext(e2[i]) - ext(s1_pts_next.p2[i]);
            s1_r_next[i]      = ext(s1_pts_next.p1[i]) - ext(s1_pts_next.p2[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pts_reg <= s1_pts_next;
            s1_r_reg   <= s1_r_next;
        end
    end

    // ---------------------------------------------------------------- stage 2
    prod_t s2_aa_reg [3];
    prod_t s2_ee_reg [3];
    prod_t s2_bb_reg [3];
    prod_t s2_cc_reg [3];
    prod_t s2_ff_reg [3];
    pts_t  s2_pts_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_aa_reg[i] <= s1_pts_reg.d1[i] * s1_pts_reg.d1[i];
                s2_ee_reg[i] <= s1_pts_reg.d2[i] * s1_pts_reg.d2[i];
                s2_bb_reg[i] <= s1_pts_reg.d1[i] * s1_pts_reg.d2[i];
                s2_cc_reg[i] <= s1_pts_reg.d1[i] * s1_r_reg[i];
                s2_ff_reg[i] <= s1_pts_reg.d2[i] * s1_r_reg[i];
            end
            s2_pts_reg <= s1_pts_reg;
        end
    end

    // ---------------------------------------------------------------- stage 3
    dot_t s3_a_reg;
    dot_t s3_e_reg;
    dot_t s3_b_reg;
    dot_t s3_c_reg;
    dot_t s3_f_reg;
    pts_t s3_pts_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_a_reg   <= dot_floor(s2_aa_reg[0], s2_aa_reg[1], s2_aa_reg[2]);
            s3_e_reg   <= dot_floor(s2_ee_reg[0], s2_ee_reg[1], s2_ee_reg[2]);
            s3_b_reg   <= dot_floor(s2_bb_reg[0], s2_bb_reg[1], s2_bb_reg[2]);
            s3_c_reg   <= dot_floor(s2_cc_reg[0], s2_cc_reg[1], s2_cc_reg[2]);
            s3_f_reg   <= dot_floor(s2_ff_reg[0], s2_ff_reg[1], s2_ff_reg[2]);
            s3_pts_reg <= s2_pts_reg;
        end
    end

    // ---------------------------------------------------------------- stage 4
    part4_t s4_pp_reg [4];
    dot_t   s4_a_reg;
    dot_t   s4_c_reg;
    geo_t   s4_geo_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_pp_reg[0]    <= split_mul(s3_a_reg, s3_e_reg);
            s4_pp_reg[1]    <= split_mul(s3_b_reg, s3_b_reg);
            s4_pp_reg[2]    <= split_mul(s3_b_reg, s3_f_reg);
            s4_pp_reg[3]    <= split_mul(s3_c_reg, s3_e_reg);
            s4_a_reg        <= s3_a_reg;
            s4_c_reg        <= s3_c_reg;
            s4_geo_reg.pts  <= s3_pts_reg;
            s4_geo_reg.b    <= s3_b_reg;
            s4_geo_reg.e    <= s3_e_reg;
            s4_geo_reg.f    <= s3_f_reg;
            s4_geo_reg.adeg <= $unsigned(s3_a_reg) <= KW'(lim_reg);
            s4_geo_reg.edeg <= $unsigned(s3_e_reg) <= KW'(lim_reg);
        end
    end

    // ---------------------------------------------------------------- stage 5
    wide_t s5_ae_reg;
    wide_t s5_bb_reg;
    wide_t s5_bf_reg;
    wide_t s5_ce_reg;
    dot_t  s5_a_reg;
    dot_t  s5_c_reg;
    geo_t  s5_geo_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_ae_reg  <= join_parts(s4_pp_reg[0]);
            s5_bb_reg  <= join_parts(s4_pp_reg[1]);
            s5_bf_reg  <= join_parts(s4_pp_reg[2]);
            s5_ce_reg  <= join_parts(s4_pp_reg[3]);
            s5_a_reg   <= s4_a_reg;
            s5_c_reg   <= s4_c_reg;
            s5_geo_reg <= s4_geo_reg;
        end
    end

    // ---------------------------------------------------------------- stage 6
    wide_t denom_next;
    wide_t nums_next;
    rat_t  numa_next;
    rat_t  dena_next;
    rat_t  s6_numa_reg;
    rat_t  s6_dena_reg;
    rat_t  s6_numb_reg;
    rat_t  s6_numc_reg;
    rat_t  s6_denbc_reg;
    geo_t  s6_geo_reg;

    assign denom_next = s5_ae_reg - s5_bb_reg;
    assign nums_next  = s5_bf_reg - s5_ce_reg;

    // Divider A: t if segment one is a point, else unclamped-t s or zero.
    always_comb
    begin
        priority if (s5_geo_reg.adeg)
        begin
            numa_next = RATIO_W_P'(s5_geo_reg.f);
            dena_next = RATIO_W_P'(s5_geo_reg.e);
        end
        else if (!s5_geo_reg.edeg && denom_next > 0)
        begin
            numa_next = nums_next[RATIO_W_P-1:0];
            dena_next = denom_next[RATIO_W_P-1:0];
        end
        else
        begin
            numa_next = '0;
            dena_next = rat_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_numa_reg  <= numa_next;
            s6_dena_reg  <= dena_next;
            s6_numb_reg  <= -RATIO_W_P'(s5_c_reg);
            s6_numc_reg  <= RATIO_W_P'(s5_geo_reg.b) - RATIO_W_P'(s5_c_reg);
            s6_denbc_reg <= RATIO_W_P'(s5_a_reg);
            s6_geo_reg   <= s5_geo_reg;
        end
    end

    // ------------------------------------------------------- first divider span
    frac_t qa;
    frac_t qb;
    frac_t qc;
    geo_t  geo_line_reg [DIV_LAT];

    sscp_ratio #(.W(RATIO_W_P)) u_div_a (
        .clk (clk), .en (adv), .num (s6_numa_reg), .den (s6_dena_reg), .q (qa)
    );
    sscp_ratio #(.W(RATIO_W_P)) u_div_b (
        .clk (clk), .en (adv), .num (s6_numb_reg), .den (s6_denbc_reg), .q (qb)
    );
    sscp_ratio #(.W(RATIO_W_P)) u_div_c (
        .clk (clk), .en (adv), .num (s6_numc_reg), .den (s6_denbc_reg), .q (qc)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            geo_line_reg[0] <= s6_geo_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                geo_line_reg[k] <= geo_line_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------- stage 7
    bs_t   s7_prod_reg;
    frac_t s7_sa_reg;
    frac_t s7_sb_reg;
    frac_t s7_sc_reg;
    geo_t  s7_geo_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_prod_reg <= geo_line_reg[DIV_LAT-1].b * $signed({1'b0, qa});
            s7_sa_reg   <= qa;
            s7_sb_reg   <= qb;
            s7_sc_reg   <= qc;
            s7_geo_reg  <= geo_line_reg[DIV_LAT-1];
        end
    end

    // ---------------------------------------------------------------- stage 8
    rat_t  numt_next;
    rat_t  eone_next;
    rat_t  s8_num_reg;
    rat_t  s8_eone_reg;
    tail_t s8_tail_reg;

    assign numt_next = RATIO_W_P'(s7_prod_reg) + (RATIO_W_P'(s7_geo_reg.f) <<< FRAC);
    assign eone_next = RATIO_W_P'(s7_geo_reg.e) <<< FRAC;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_num_reg       <= numt_next;
            s8_eone_reg      <= eone_next;
            s8_tail_reg.geo  <= s7_geo_reg;
            s8_tail_reg.sa   <= s7_sa_reg;
            s8_tail_reg.sb   <= s7_sb_reg;
            s8_tail_reg.sc   <= s7_sc_reg;
            s8_tail_reg.neg  <= numt_next < 0;
            s8_tail_reg.over <= numt_next > eone_next;
        end
    end

    // ------------------------------------------------------ second divider span
    frac_t qd;
    tail_t tail_line_reg [DIV_LAT];

    sscp_ratio #(.W(RATIO_W_P)) u_div_d (
        .clk (clk), .en (adv), .num (s8_num_reg), .den (s8_eone_reg), .q (qd)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_line_reg[0] <= s8_tail_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                tail_line_reg[k] <= tail_line_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------- stage 9
    tail_t tl;
    frac_t s_next;
    frac_t t_next;
    frac_t s9_s_reg;
    frac_t s9_t_reg;
    pts_t  s9_pts_reg;

    assign tl = tail_line_reg[DIV_LAT-1];

    always_comb
    begin
        priority if (tl.geo.adeg && tl.geo.edeg)
        begin
            s_next = '0;
            t_next = '0;
        end
        else if (tl.geo.adeg)
        begin
            s_next = '0;
            t_next = tl.sa;
        end
        else if (tl.geo.edeg || tl.neg)
        begin
            s_next = tl.sb;
            t_next = '0;
        end
        else if (tl.over)
        begin
            s_next = tl.sc;
            t_next = ONE_Q16;
        end
        else
        begin
            s_next = tl.sa;
            t_next = qd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_s_reg   <= s_next;
            s9_t_reg   <= t_next;
            s9_pts_reg <= tl.geo.pts;
        end
    end

    // --------------------------------------------------------------- stage 10
    mul_t  s10_m1_reg [3];
    mul_t  s10_m2_reg [3];
    frac_t s10_s_reg;
    frac_t s10_t_reg;
    pts_t  s10_pts_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s10_m1_reg[i] <= s9_pts_reg.d1[i] * $signed({1'b0, s9_s_reg});
                s10_m2_reg[i] <= s9_pts_reg.d2[i] * $signed({1'b0, s9_t_reg});
            end
            s10_s_reg   <= s9_s_reg;
            s10_t_reg   <= s9_t_reg;
            s10_pts_reg <= s9_pts_reg;
        end
    end

    // --------------------------------------------------------------- stage 11
    coord_t s11_c1_reg [3];
    coord_t s11_c2_reg [3];
    frac_t  s11_s_reg;
    frac_t  s11_t_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s11_c1_reg[i] <= CW'(ext(s10_pts_reg.p1[i]) + DW'(s10_m1_reg[i] >>> FRAC));
                s11_c2_reg[i] <= CW'(ext(s10_pts_reg.p2[i]) + DW'(s10_m2_reg[i] >>> FRAC));
            end
            s11_s_reg <= s10_s_reg;
            s11_t_reg <= s10_t_reg;
        end
    end

    // --------------------------------------------------------------- stage 12
    diff_t  gapd_next [3];
    prod_t  s12_sq_reg [3];
    coord_t s12_c1_reg [3];
    coord_t s12_c2_reg [3];
    frac_t  s12_s_reg;
    frac_t  s12_t_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            gapd_next[i] = ext(s11_c1_reg[i]) - ext(s11_c2_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s12_sq_reg[i] <= gapd_next[i] * gapd_next[i];
            end
            s12_c1_reg <= s11_c1_reg;
            s12_c2_reg <= s11_c2_reg;
            s12_s_reg  <= s11_s_reg;
            s12_t_reg  <= s11_t_reg;
        end
    end

    // ------------------------------------------------------- stage 13 / output
    logic [PW+1:0]      sqsum_next;
    logic [PW+1-FRAC:0] gsh_next;
    gap_t               gap_next;
    coord_t             out_c1_reg [3];
    coord_t             out_c2_reg [3];
    frac_t              out_s_reg;
    frac_t              out_t_reg;
    gap_t               out_gap_reg;

    assign sqsum_next = {2'b00, s12_sq_reg[0]} + {2'b00, s12_sq_reg[1]}
                      + {2'b00, s12_sq_reg[2]};
    assign gsh_next   = sqsum_next[PW+1:FRAC];
    // Saturate at the field maximum.
    assign gap_next   = (gsh_next > (PW+2-FRAC)'(GAP_MAX)) ? GAP_MAX : GW'(gsh_next);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_c1_reg  <= s12_c1_reg;
            out_c2_reg  <= s12_c2_reg;
            out_s_reg   <= s12_s_reg;
            out_t_reg   <= s12_t_reg;
            out_gap_reg <= gap_next;
        end
    end

    assign result.param_first  = out_s_reg;
    assign result.param_second = out_t_reg;
    assign result.near1_x      = out_c1_reg[0];
    assign result.near1_y      = out_c1_reg[1];
    assign result.near1_z      = out_c1_reg[2];
    assign result.near2_x      = out_c2_reg[0];
    assign result.near2_y      = out_c2_reg[1];
    assign result.near2_z      = out_c2_reg[2];
    assign result.gap_squared  = out_gap_reg;

endmodule

// File: rtl/core/sscp_checker.sv
// Port-level checks for the segment closest-point block, bound to the top level.
module sscp_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            q_ready,
    input logic            r_valid,
    input logic            r_ready,
    input sscp_pkg::frac_t r_first,
    input sscp_pkg::frac_t r_second,
    input sscp_pkg::gap_t  r_gap
);
    import sscp_pkg::*;

    // Query side moves exactly when the result register can advance.
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready == (!r_valid || r_ready))
        else $error("query ready does not track result register");

    a_first_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> r_first <= ONE_Q16)
        else $error("param_first above one");

    a_second_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> r_second <= ONE_Q16)
        else $error("param_second above one");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_gap) && $stable(r_first))
        else $error("stalled result transaction changed");

endmodule

bind segment_segment_closest_points sscp_checker u_sscp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_ready  (query.ready),
    .r_valid  (result.valid),
    .r_ready  (result.ready),
    .r_first  (result.param_first),
    .r_second (result.param_second),
    .r_gap    (result.gap_squared)
);
